// ===== rtl/les_pkg.sv =====
package les_pkg;

   localparam int MaxEdges = 32;
   localparam int IdBits = 16;
   localparam int IdxBits = $clog2(MaxEdges);
   localparam int CntBits = $clog2(MaxEdges + 1);

   typedef struct packed {
      logic [15:0] edge_from;
      logic [15:0] edge_to;
      logic last_edge;
   } req_type;

   typedef struct packed {
      logic [15:0] out_from;
      logic [15:0] out_to;
      logic is_leaf_edge;
      logic [5:0] kept_count;
      logic overflow;
      logic last_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_CAND,
      ST_COUNT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic cand_init;
      logic cand_step;
      logic count_init;
      logic count_step;
      logic scan_init;
      logic scan_step;
      logic emit_init;
      logic emit_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_done;
      logic cand_done;
      logic count_done;
      logic scan_done;
      logic emit_done;
   } sts_type;

endpackage

// ===== rtl/les_ctrl.sv =====
module les_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  les_pkg::sts_type sts,
   output les_pkg::cmd_type cmd,
   output logic busy
);
   import les_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (start && sts.load_done) begin
               state_in = ST_CAND;
            end
         end
         ST_CAND: begin
            if (sts.cand_done) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (sts.count_done) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_CAND;
            end
         end
         ST_EMIT: begin
            if (sts.emit_done) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            busy = 1'b0;
            cmd.load = start;
            cmd.cand_init = start && sts.load_done;
         end
         ST_CAND: begin
            cmd.count_init = !sts.cand_done;
            cmd.emit_init = sts.cand_done;
         end
         ST_COUNT: begin
            cmd.count_step = 1'b1;
            cmd.scan_init = sts.count_done;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.cand_step = sts.scan_done;
         end
         ST_EMIT: begin
            cmd.emit_step = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && sts.emit_done) |=> !busy)
      else $error("emission end did not return to load");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.count_step, cmd.scan_step, cmd.emit_step, cmd.load}))
      else $error("datapath commands overlap");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CAND) |=> (state_ff == ST_COUNT || state_ff == ST_EMIT))
      else $error("bad step after candidate");

endmodule

// ===== rtl/les_dp.sv =====
module les_dp (
   input  logic clock,
   input  logic reset,
   input  les_pkg::req_type req,
   input  les_pkg::cmd_type cmd,
   output les_pkg::sts_type sts,
   output logic rsp_valid,
   output les_pkg::rsp_type rsp
);
   import les_pkg::*;

   // Edge stores: each read at a fixed slot plus chosen slots, kept in flops (32 entries).
   logic [IdBits-1:0] from_ff [MaxEdges];
   logic [IdBits-1:0] to_ff [MaxEdges];
   logic [CntBits-1:0] count_ff;
   logic [CntBits-1:0] end_ff;
   logic ovf_ff;

   // Leaf search: the candidate is the smallest id above the previous one.
   logic [IdBits-1:0] prev_ff;
   logic prev_valid_ff;
   logic [IdBits-1:0] best_ff;
   logic best_valid_ff;
   logic [1:0] occ_ff;
   logic [CntBits-1:0] idx_ff;
   logic [IdxBits-1:0] hit_idx_ff;
   logic hit_ff;
   logic hit_swap_ff;
   logic phase_ff;
   logic no_cand_ff;

   logic [IdxBits-1:0] idx;
   logic [IdBits-1:0] f_k, t_k;
   logic above_f, above_t;
   logic [IdBits-1:0] c_min;
   logic c_any;
   logic [1:0] occ_add;
   logic [CntBits-1:0] last;
   logic [IdxBits-1:0] li;
   logic [CntBits-1:0] emit_idx;

   assign idx = idx_ff[IdxBits-1:0];
   assign f_k = from_ff[idx];
   assign t_k = to_ff[idx];
   assign above_f = !prev_valid_ff || (f_k > prev_ff);
   assign above_t = !prev_valid_ff || (t_k > prev_ff);
   assign last = end_ff - 1'b1;
   assign li = last[IdxBits-1:0];
   assign emit_idx = idx_ff;

   always_comb begin
      c_any = above_f || above_t;
      if (above_f && above_t) begin
         c_min = (f_k < t_k) ? f_k : t_k;
      end else if (above_f) begin
         c_min = f_k;
      end else begin
         c_min = t_k;
      end
      occ_add = {1'b0, f_k == best_ff} + {1'b0, t_k == best_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         end_ff <= '0;
         ovf_ff <= 1'b0;
         rsp_valid <= 1'b0;
         prev_valid_ff <= 1'b0;
         best_valid_ff <= 1'b0;
         idx_ff <= '0;
         phase_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (cmd.load) begin
            if (count_ff < CntBits'(MaxEdges)) begin
               from_ff[count_ff[IdxBits-1:0]] <= req.edge_from[IdBits-1:0];
               to_ff[count_ff[IdxBits-1:0]] <= req.edge_to[IdBits-1:0];
               count_ff <= count_ff + 1'b1;
               end_ff <= count_ff + 1'b1;
            end else begin
               ovf_ff <= 1'b1;
               end_ff <= count_ff;
            end
         end
         if (cmd.cand_init) begin
            prev_valid_ff <= 1'b0;
         end
         if (cmd.cand_step) begin
            prev_ff <= best_ff;
            prev_valid_ff <= 1'b1;
         end
         if (cmd.count_init) begin
            idx_ff <= '0;
            phase_ff <= 1'b0;
            best_valid_ff <= 1'b0;
            occ_ff <= '0;
         end
         // Two passes: first find the candidate, then count its occurrences.
         if (cmd.count_step) begin
            if (!phase_ff) begin
               if (c_any && (!best_valid_ff || c_min < best_ff)) begin
                  best_ff <= c_min;
                  best_valid_ff <= 1'b1;
               end
               if (idx_ff == count_ff - 1'b1) begin
                  phase_ff <= 1'b1;
                  idx_ff <= '0;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end else begin
               if ({1'b0, occ_ff} + {1'b0, occ_add} > 3'd2) begin
                  occ_ff <= 2'd2;
               end else begin
                  occ_ff <= occ_ff + occ_add;
               end
               idx_ff <= idx_ff + 1'b1;
            end
         end
         if (cmd.scan_init) begin
            idx_ff <= '0;
            hit_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            if (!hit_ff && best_valid_ff && idx_ff < end_ff && occ_ff == 2'd1) begin
               if (t_k == best_ff || f_k == best_ff) begin
                  hit_ff <= 1'b1;
                  hit_idx_ff <= idx;
                  hit_swap_ff <= (t_k != best_ff);
               end
               idx_ff <= idx_ff + 1'b1;
            end else if (hit_ff) begin
               if (hit_idx_ff != li) begin
                  from_ff[hit_idx_ff] <= from_ff[li];
                  to_ff[hit_idx_ff] <= to_ff[li];
               end
               from_ff[li] <= hit_swap_ff ? to_ff[hit_idx_ff] : from_ff[hit_idx_ff];
               to_ff[li] <= hit_swap_ff ? from_ff[hit_idx_ff] : to_ff[hit_idx_ff];
               end_ff <= last;
               hit_ff <= 1'b0;
               idx_ff <= end_ff;
            end
         end
         if (cmd.emit_init) begin
            idx_ff <= '0;
         end
         if (cmd.emit_step) begin
            rsp_valid <= 1'b1;
            rsp.out_from <= 16'(from_ff[emit_idx[IdxBits-1:0]]);
            rsp.out_to <= 16'(to_ff[emit_idx[IdxBits-1:0]]);
            rsp.is_leaf_edge <= (emit_idx >= end_ff);
            rsp.kept_count <= 6'(end_ff);
            rsp.overflow <= ovf_ff;
            rsp.last_out <= (emit_idx == count_ff - 1'b1);
            idx_ff <= idx_ff + 1'b1;
            if (emit_idx == count_ff - 1'b1) begin
               count_ff <= '0;
               ovf_ff <= 1'b0;
            end
         end
      end
   end

   always_comb begin
      sts.load_done = req.last_edge;
      sts.cand_done = no_cand_ff;
      sts.count_done = phase_ff && (idx_ff == count_ff - 1'b1);
      sts.scan_done = !hit_ff && !(best_valid_ff && idx_ff < end_ff && occ_ff == 2'd1);
      sts.emit_done = (emit_idx == count_ff - 1'b1);
   end

   // The candidate search ends when no id above the previous candidate remains.
   always_ff @(posedge clock) begin
      if (reset) begin
         no_cand_ff <= 1'b0;
      end else if (cmd.count_init || cmd.cand_init) begin
         no_cand_ff <= 1'b0;
      end else if (cmd.count_step && !phase_ff && idx_ff == count_ff - 1'b1) begin
         no_cand_ff <= !(best_valid_ff || c_any);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.emit_step |=> rsp_valid)
      else $error("emission lost a transaction");
   assert property (@(posedge clock) disable iff (reset)
      end_ff <= count_ff || count_ff == '0)
      else $error("split beyond edge count");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && hit_ff) |=> end_ff == $past(end_ff) - 1'b1)
      else $error("move did not shrink unmoved region");

endmodule

// ===== rtl/leaf_edge_separation_unit.sv =====
// Channel  | Ports               | Handshake
// request  | req, start, busy    | taken when start is high and busy low
// response | rsp, rsp_valid      | one transaction per cycle, no back-pressure
// Loading takes one edge per cycle while start is high. After the last edge, each
// candidate id passes through picking it, the candidate search and occurrence count
// over the stored list of edges, and the edge scan and swap, with a further pass
// that finds no candidate, then the emission of the stored edges. Reset is synchronous
// and clears all control state.
// The receiver cannot stall; busy stays high until the last result is sent.
module leaf_edge_separation_unit (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  les_pkg::req_type req,
   output logic busy,
   output logic rsp_valid,
   output les_pkg::rsp_type rsp
);
   import les_pkg::*;

   cmd_type cmd;
   sts_type sts, sts_dp;

   les_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
   );

   les_dp u_dp (
      .clock(clock), .reset(reset), .req(req), .cmd(cmd), .sts(sts_dp),
      .rsp_valid(rsp_valid), .rsp(rsp)
   );

   assign sts = sts_dp;

endmodule
